// File: design/request_interval_abuse_checker_defines.svh
// Assertion macros used by the judging module of the request interval abuse checker.
`ifndef REQUEST_INTERVAL_ABUSE_CHECKER_DEFINES_SVH
`define REQUEST_INTERVAL_ABUSE_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rac assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RAC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rac assertion failed");

`endif

// File: design/rac_pkg.sv
// Types, register indexes and helper functions of the request interval abuse checker.
package rac_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned CsrWidth   = 16;
   localparam int unsigned IndexWidth = 3;

   typedef logic [CountWidth-1:0] count_type;

   // Configuration register indexes.
   typedef enum logic [IndexWidth-1:0] {
      REG_MIN_INTERVAL      = 3'd0,
      REG_PASS_RUN_LIMIT    = 3'd1,
      REG_GOOD_RUN_LIMIT    = 3'd2,
      REG_SINGLE_MISS_LIMIT = 3'd3,
      REG_BURST_MISS_LIMIT  = 3'd4,
      REG_PENALTY_LIMIT     = 3'd5
   } reg_index_type;

   // Item modes.
   localparam logic MODE_REQUEST = 1'b0;
   localparam logic MODE_CLEAR   = 1'b1;

   typedef struct packed {
      logic [CsrWidth-1:0] min_interval;
      count_type           pass_run_limit;
      count_type           good_run_limit;
      count_type           single_miss_limit;
      count_type           burst_miss_limit;
      count_type           penalty_limit;
   } cfg_type;

   typedef struct packed {
      logic                 mode;
      logic [TimeWidth-1:0] req_time;
   } item_type;

   typedef struct packed {
      logic valid;
      item_type item;
   } stage_type;

   typedef struct packed {
      logic close_now;
      logic accepted;
   } result_type;

   // Counter increment that sticks at its maximum.
   function automatic count_type sat_inc(input count_type v);
      count_type r;
      r = (v == '1) ? v : count_type'(v + 1'b1);
      return r;
   endfunction

   // Counter decrement that sticks at zero.
   function automatic count_type sat_dec(input count_type v);
      count_type r;
      r = (v == '0) ? v : count_type'(v - 1'b1);
      return r;
   endfunction

endpackage

// File: design/rac_csr.sv
// Configuration registers of the request interval abuse checker.
module rac_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [rac_pkg::IndexWidth-1:0] csr_index,
   input  logic [rac_pkg::CsrWidth-1:0]  csr_wdata,
   output rac_pkg::cfg_type              cfg
);
   import rac_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; indexes beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MIN_INTERVAL:      cfg_in.min_interval      = csr_wdata;
            REG_PASS_RUN_LIMIT:    cfg_in.pass_run_limit    = csr_wdata[CountWidth-1:0];
            REG_GOOD_RUN_LIMIT:    cfg_in.good_run_limit    = csr_wdata[CountWidth-1:0];
            REG_SINGLE_MISS_LIMIT: cfg_in.single_miss_limit = csr_wdata[CountWidth-1:0];
            REG_BURST_MISS_LIMIT:  cfg_in.burst_miss_limit  = csr_wdata[CountWidth-1:0];
            REG_PENALTY_LIMIT:     cfg_in.penalty_limit     = csr_wdata[CountWidth-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank with its reset defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_interval      <= 16'd500;
         cfg_ff.pass_run_limit    <= 4'd3;
         cfg_ff.good_run_limit    <= 4'd2;
         cfg_ff.single_miss_limit <= 4'd10;
         cfg_ff.burst_miss_limit  <= 4'd3;
         cfg_ff.penalty_limit     <= 4'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/rac_in_reg.sv
// Input register stage that holds one request item ahead of the judging logic.
module rac_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rac_pkg::item_type   req_item,
   input  logic                take_ready,
   output rac_pkg::stage_type  stage,
   output logic                advance
);
   import rac_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   // The stage moves on when the result register can take its item.
   assign advance    = valid_ff && take_ready;
   assign req_tready = !valid_ff || take_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// File: design/rac_judge.sv
// Gap check, penalty counters and verdict for one request item.
`include "request_interval_abuse_checker_defines.svh"
module rac_judge (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  rac_pkg::item_type   item,
   input  rac_pkg::cfg_type    cfg,
   output rac_pkg::result_type result
);
   import rac_pkg::*;

   logic [TimeWidth-1:0] last_time_ff, last_time_in;
   logic                 prev_passed_ff, prev_passed_in;
   count_type            pass_run_ff, pass_run_in;
   count_type            good_runs_ff, good_runs_in;
   count_type            single_misses_ff, single_misses_in;
   count_type            burst_misses_ff, burst_misses_in;
   count_type            penalties_ff, penalties_in;

   logic [TimeWidth-1:0] gap;
   logic                 gap_ok;
   count_type            run_cnt;
   count_type            good_cnt;
   count_type            single_cnt;
   count_type            burst_cnt;
   count_type            pen_cnt;
   count_type            pen_cnt2;

   assign gap    = item.req_time - last_time_ff;
   assign gap_ok = gap >= {{(TimeWidth-CsrWidth){1'b0}}, cfg.min_interval};

   // Next state and verdict, following the order of the counter updates.
   always_comb begin
      last_time_in     = last_time_ff;
      prev_passed_in   = prev_passed_ff;
      pass_run_in      = pass_run_ff;
      good_runs_in     = good_runs_ff;
      single_misses_in = single_misses_ff;
      burst_misses_in  = burst_misses_ff;
      penalties_in     = penalties_ff;
      result.accepted  = 1'b1;
      result.close_now = 1'b0;
      run_cnt          = pass_run_ff;
      good_cnt         = good_runs_ff;
      single_cnt       = single_misses_ff;
      burst_cnt        = burst_misses_ff;
      pen_cnt          = penalties_ff;
      pen_cnt2         = penalties_ff;
      priority if (item.mode == MODE_CLEAR) begin
         last_time_in = '0;
      end else if (last_time_ff == '0) begin
         // No earlier request known: only store the time.
         last_time_in = item.req_time;
      end else begin
         last_time_in = item.req_time;
         if (gap_ok) begin
            run_cnt        = prev_passed_ff ? sat_inc(pass_run_ff) : pass_run_ff;
            prev_passed_in = 1'b1;
            pass_run_in    = run_cnt;
            if (run_cnt >= cfg.pass_run_limit) begin
               // A good run completes and pays back a burst count; enough good runs pay back a penalty.
               burst_misses_in = sat_dec(burst_misses_ff);
               pass_run_in     = '0;
               good_cnt        = sat_inc(good_runs_ff);
               good_runs_in    = good_cnt;
               if (good_cnt >= cfg.good_run_limit) begin
                  good_runs_in = '0;
                  penalties_in = sat_dec(penalties_ff);
               end
            end
         end else begin
            pass_run_in    = '0;
            prev_passed_in = 1'b0;
            if (prev_passed_ff) begin
               // Isolated miss.
               single_cnt       = sat_inc(single_misses_ff);
               single_misses_in = single_cnt;
               if (single_cnt >= cfg.single_miss_limit) begin
                  single_misses_in = '0;
                  pen_cnt          = sat_inc(penalties_ff);
               end
            end else begin
               burst_cnt = sat_inc(burst_misses_ff);
            end
            // Back-to-back misses.
            burst_misses_in = burst_cnt;
            pen_cnt2        = pen_cnt;
            if (burst_cnt >= cfg.burst_miss_limit) begin
               result.accepted = 1'b0;
               burst_misses_in = '0;
               pen_cnt2        = sat_inc(pen_cnt);
            end
            // Penalty limit drops the requester.
            penalties_in = pen_cnt2;
            if (pen_cnt2 >= cfg.penalty_limit) begin
               result.accepted  = 1'b0;
               result.close_now = 1'b1;
               penalties_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff     <= '0;
         prev_passed_ff   <= 1'b0;
         pass_run_ff      <= '0;
         good_runs_ff     <= '0;
         single_misses_ff <= '0;
         burst_misses_ff  <= '0;
         penalties_ff     <= '0;
      end else if (fire) begin
         last_time_ff     <= last_time_in;
         prev_passed_ff   <= prev_passed_in;
         pass_run_ff      <= pass_run_in;
         good_runs_ff     <= good_runs_in;
         single_misses_ff <= single_misses_in;
         burst_misses_ff  <= burst_misses_in;
         penalties_ff     <= penalties_in;
      end
   end

   // A dropped requester is never accepted.
   `RAC_ASSERT_NOW(a_close_rejects, clock, reset, fire && result.close_now, !result.accepted)
   // A clear item forgets the stored time.
   `RAC_ASSERT_NEXT(a_clear_forgets, clock, reset, fire && (item.mode == MODE_CLEAR), last_time_ff == '0)
   // Closing restarts the penalty count.
   `RAC_ASSERT_NEXT(a_close_restarts, clock, reset, fire && result.close_now, penalties_ff == '0)
   // Clear items leave the counters unchanged.
   `RAC_ASSERT_NEXT(a_clear_keeps, clock, reset, fire && (item.mode == MODE_CLEAR), $stable(penalties_ff) && $stable(prev_passed_ff))

endmodule

// File: design/request_interval_abuse_checker.sv
// Path: an accepted item waits in the input register until the result register is free,
// then its verdict is registered into the result register, which drives rsp_tvalid.
// Throughput: one item per cycle; the input register and the result register
// both move whenever the result register is empty or being drained.
// Reset: synchronous; clears the stored time, all counters and both valid
// flags, and loads the configuration defaults.
module request_interval_abuse_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // [31:0] req_time
   input  logic                           req_tuser,  // [0] mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // [0] accepted, [1] close_now
   input  logic                           csr_we,
   input  logic [rac_pkg::IndexWidth-1:0] csr_index,
   input  logic [rac_pkg::CsrWidth-1:0]   csr_wdata
);
   import rac_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   stage_type  stage;
   logic       advance;
   logic       take_ready;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_item.mode     = req_tuser;
   assign req_item.req_time = req_tdata;

   rac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rac_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take_ready (take_ready),
      .stage      (stage),
      .advance    (advance)
   );

   rac_judge u_judge (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (stage.item),
      .cfg    (cfg),
      .result (result)
   );

   // Result register: takes a new item when empty or being drained.
   assign take_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.close_now, rsp_ff.accepted};

endmodule
